[sv/chp2h_pkg.sv]
package chp2h_pkg;

    // default geometry and counter width
    localparam int GridWidthDef  = 256;
    localparam int GridHeightDef = 256;
    localparam int CountBitsDef  = 32;

    // request codes
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // configuration register indexes
    localparam int CfgIdxBits = 3;
    localparam logic [CfgIdxBits-1:0] CFG_MIN_REAL     = 3'd0;
    localparam logic [CfgIdxBits-1:0] CFG_MIN_IMAG     = 3'd1;
    localparam logic [CfgIdxBits-1:0] CFG_MAX_REAL     = 3'd2;
    localparam logic [CfgIdxBits-1:0] CFG_MAX_IMAG     = 3'd3;
    localparam logic [CfgIdxBits-1:0] CFG_INV_BIN_REAL = 3'd4;
    localparam logic [CfgIdxBits-1:0] CFG_INV_BIN_IMAG = 3'd5;

    // configuration reset values
    localparam logic [31:0] MinRealRst    = 32'hFFFE_0000;
    localparam logic [31:0] MinImagRst    = 32'hFFFE_0000;
    localparam logic [31:0] MaxRealRst    = 32'h0002_0000;
    localparam logic [31:0] MaxImagRst    = 32'h0002_0000;
    localparam logic [31:0] InvBinRealRst = 32'h0040_0000;
    localparam logic [31:0] InvBinImagRst = 32'h0040_0000;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MOD,
        B_RDATA,
        B_DIV,
        B_OUT
    } back_state_t;

    // one result item
    typedef struct packed {
        logic        accepted;
        logic [31:0] cell_count;
        logic [7:0]  grey_level;
        logic        grey_valid;
        logic [31:0] peak_count;
    } res_t;

endpackage

[sv/chp2h_queue.sv]
module chp2h_queue #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] head_data,
    output logic          full,
    output logic          empty
);

    logic [DW-1:0] entry_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    fill_reg;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    assign head_data = entry_reg[rd_ptr_reg];
    assign full      = fill_reg[1];
    assign empty     = (fill_reg == 2'd0);

endmodule

[sv/chp2h_front.sv]
module chp2h_front #(
    parameter int GRID_WIDTH  = chp2h_pkg::GridWidthDef,
    parameter int GRID_HEIGHT = chp2h_pkg::GridHeightDef,
    parameter int AW          = 16,
    parameter int QW          = AW + 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [chp2h_pkg::CfgIdxBits-1:0]    cfg_index,
    input  logic [31:0]                         cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          req_type,
    input  logic signed [31:0]                  point_re,
    input  logic signed [31:0]                  point_im,
    input  logic [7:0]                          cell_x,
    input  logic [7:0]                          cell_y,
    input  logic                                sweep_busy,
    output logic                                q_push,
    output logic [QW-1:0]                       q_data,
    input  logic                                q_full
);
    import chp2h_pkg::*;

    localparam int XW = $clog2(GRID_WIDTH);
    localparam int YW = $clog2(GRID_HEIGHT);

    logic [31:0] min_real_reg, min_imag_reg, max_real_reg, max_imag_reg;
    logic [31:0] inv_re_reg, inv_im_reg;

    front_state_t state_reg, state_next;
    req_t         req_reg;
    logic [31:0]  re_reg, im_reg;
    logic [7:0]   cx_reg, cy_reg;
    logic         in_box_reg;
    logic [63:0]  prod_re_reg, prod_im_reg;

    logic         accept;
    logic         in_box;
    logic [31:0]  diff_re, diff_im;
    logic [31:0]  idx_re, idx_im;
    logic [XW-1:0] bin_x;
    logic [YW-1:0] bin_y;
    logic         hit;
    logic [AW-1:0] addr;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_real_reg <= MinRealRst;
            min_imag_reg <= MinImagRst;
            max_real_reg <= MaxRealRst;
            max_imag_reg <= MaxImagRst;
            inv_re_reg   <= InvBinRealRst;
            inv_im_reg   <= InvBinImagRst;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_REAL:     min_real_reg <= cfg_data;
                CFG_MIN_IMAG:     min_imag_reg <= cfg_data;
                CFG_MAX_REAL:     max_real_reg <= cfg_data;
                CFG_MAX_IMAG:     max_imag_reg <= cfg_data;
                CFG_INV_BIN_REAL: inv_re_reg   <= cfg_data;
                CFG_INV_BIN_IMAG: inv_im_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign accept = in_valid && !in_stall;

    // range check and offsets from the lower bounds
    assign in_box = !($signed(re_reg) < $signed(min_real_reg) ||
                      $signed(im_reg) < $signed(min_imag_reg) ||
                      $signed(re_reg) > $signed(max_real_reg) ||
                      $signed(im_reg) > $signed(max_imag_reg));
    assign diff_re = re_reg - min_real_reg;
    assign diff_im = im_reg - min_imag_reg;

    // bin index with clamp to the last bin
    assign idx_re = prod_re_reg[63:32];
    assign idx_im = prod_im_reg[63:32];
    assign bin_x  = (idx_re >= 32'(GRID_WIDTH))  ? XW'(GRID_WIDTH - 1)  : idx_re[XW-1:0];
    assign bin_y  = (idx_im >= 32'(GRID_HEIGHT)) ? YW'(GRID_HEIGHT - 1) : idx_im[YW-1:0];

    // classify into address and hit flag
    always_comb
    begin
        hit  = 1'b0;
        addr = '0;
        unique case (req_reg)
            REQ_INSERT:
            begin
                hit  = in_box_reg;
                addr = AW'(AW'(bin_y) * AW'(GRID_WIDTH) + AW'(bin_x));
            end
            REQ_READ:
            begin
                hit  = (32'(cx_reg) < 32'(GRID_WIDTH)) && (32'(cy_reg) < 32'(GRID_HEIGHT));
                addr = hit ? AW'(AW'(cy_reg) * AW'(GRID_WIDTH) + AW'(cx_reg)) : '0;
            end
            default:
            begin
                hit  = 1'b0;
                addr = '0;
            end
        endcase
    end

    assign q_data = {req_reg, hit, addr};

    // item capture and products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_t'(req_type);
            re_reg  <= point_re;
            im_reg  <= point_im;
            cx_reg  <= cell_x;
            cy_reg  <= cell_y;
        end
        if (state_reg == F_MUL)
        begin
            in_box_reg  <= in_box;
            prod_re_reg <= 64'(diff_re) * 64'(inv_re_reg);
            prod_im_reg <= 64'(diff_im) * 64'(inv_im_reg);
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_stall = sweep_busy;
                if (accept)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

[sv/chp2h_div.sv]
module chp2h_div #(
    parameter int COUNT_BITS = chp2h_pkg::CountBitsDef
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COUNT_BITS-1:0] count,
    input  logic [COUNT_BITS-1:0] peak,
    output logic                  done,
    output logic [7:0]            grey
);

    localparam int NB = COUNT_BITS + 8;
    localparam int SW = $clog2(NB + 1);

    logic [NB-1:0]         dvd_reg;
    logic [NB-1:0]         q_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] dsr_reg;
    logic [SW-1:0]         step_reg;
    logic                  run_reg;
    logic                  done_reg;

    logic [COUNT_BITS:0]   shifted;
    logic                  fits;

    // one quotient bit per cycle
    assign shifted = {rem_reg, dvd_reg[NB-1]};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= (NB'(count) << 8) - NB'(count);
            dsr_reg <= peak;
            rem_reg <= '0;
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            dvd_reg <= {dvd_reg[NB-2:0], 1'b0};
            rem_reg <= fits ? COUNT_BITS'(shifted - {1'b0, dsr_reg}) : shifted[COUNT_BITS-1:0];
            q_reg   <= {q_reg[NB-2:0], fits};
        end
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= '0;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + SW'(1);
                if (step_reg == SW'(NB - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign grey = (|q_reg[NB-1:8]) ? 8'hFF : q_reg[7:0];

endmodule

[sv/chp2h_back.sv]
module chp2h_back #(
    parameter int GRID_WIDTH  = chp2h_pkg::GridWidthDef,
    parameter int GRID_HEIGHT = chp2h_pkg::GridHeightDef,
    parameter int COUNT_BITS  = chp2h_pkg::CountBitsDef,
    parameter int AW          = 16,
    parameter int QW          = AW + 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [QW-1:0]        q_data,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 sweep_busy,
    output logic                 out_valid,
    input  logic                 out_stall,
    output chp2h_pkg::res_t      out_res
);
    import chp2h_pkg::*;

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam logic [COUNT_BITS-1:0] CountMax = '1;

    logic [COUNT_BITS-1:0] mem [CELLS];

    back_state_t           state_reg, state_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic                  clr_res_reg, clr_res_next;
    logic [COUNT_BITS-1:0] peak_reg, peak_next;
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  hit_reg;
    logic [AW-1:0]         addr_reg;
    res_t                  res_reg;
    logic                  out_valid_reg;
    res_t                  out_res_reg;

    req_t                  q_req;
    logic                  q_hit;
    logic [AW-1:0]         q_addr;
    logic                  out_free;
    logic                  emit;
    res_t                  emit_res;
    logic                  out_load;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] new_cnt;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic                  div_start;
    logic                  div_done;
    logic [7:0]            div_grey;

    assign q_req  = req_t'(q_data[QW-1 -: 2]);
    assign q_hit  = q_data[AW];
    assign q_addr = q_data[AW-1:0];

    assign out_free = !out_valid_reg || !out_stall;
    assign new_cnt  = (rd_data_reg == CountMax) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);
    assign rd_cnt   = hit_reg ? rd_data_reg : '0;

    chp2h_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .count (cnt_next),
        .peak  (peak_reg),
        .done  (div_done),
        .grey  (div_grey)
    );

    // count memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[q_addr];
            hit_reg     <= q_hit;
            addr_reg    <= q_addr;
        end
        cnt_reg <= cnt_next;
        if (emit && !out_free)
        begin
            res_reg <= emit_res;
        end
        if (out_load)
        begin
            out_res_reg <= (state_reg == B_OUT) ? res_reg : emit_res;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            clr_res_reg   <= 1'b0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_res_reg  <= clr_res_next;
            peak_reg     <= peak_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // sequencer for memory, peak and results
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        clr_res_next  = clr_res_reg;
        peak_next     = peak_reg;
        cnt_next      = cnt_reg;
        q_pop         = 1'b0;
        emit          = 1'b0;
        emit_res      = '0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = new_cnt;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == AW'(CELLS - 1))
                begin
                    clr_res_next = 1'b0;
                    state_next   = B_IDLE;
                    emit         = clr_res_reg;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + AW'(1);
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    unique case (q_req)
                        REQ_INSERT:
                        begin
                            if (q_hit)
                            begin
                                state_next = B_MOD;
                            end
                            else
                            begin
                                emit                = 1'b1;
                                emit_res.peak_count = 32'(peak_reg);
                            end
                        end
                        REQ_READ:
                        begin
                            state_next = B_RDATA;
                        end
                        REQ_CLEAR:
                        begin
                            peak_next     = '0;
                            clr_addr_next = '0;
                            clr_res_next  = 1'b1;
                            state_next    = B_CLEAR;
                        end
                        REQ_NONE:
                        begin
                            emit                = 1'b1;
                            emit_res.peak_count = 32'(peak_reg);
                        end
                        default: ;
                    endcase
                end
            end
            B_MOD:
            begin
                mem_we = 1'b1;
                if (new_cnt > peak_reg)
                begin
                    peak_next = new_cnt;
                end
                emit                = 1'b1;
                emit_res.accepted   = 1'b1;
                emit_res.peak_count = 32'(peak_next);
            end
            B_RDATA:
            begin
                cnt_next = rd_cnt;
                if (peak_reg == '0)
                begin
                    emit                = 1'b1;
                    emit_res.cell_count = 32'(rd_cnt);
                    emit_res.peak_count = 32'(peak_reg);
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    emit                = 1'b1;
                    emit_res.cell_count = 32'(cnt_reg);
                    emit_res.grey_level = div_grey;
                    emit_res.grey_valid = 1'b1;
                    emit_res.peak_count = 32'(peak_reg);
                end
            end
            B_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
        // finished item goes straight out or waits in the result register
        if (emit)
        begin
            if (out_free)
            begin
                out_load   = 1'b1;
                state_next = B_IDLE;
            end
            else
            begin
                state_next = B_OUT;
            end
        end
    end

    assign sweep_busy = (state_reg == B_CLEAR);
    assign out_valid  = out_valid_reg;
    assign out_res    = out_res_reg;

endmodule

[sv/complex_point_2d_histogram.sv]
// channel  direction  handshake            payload
// cfg      in         cfg_wr_en            cfg_index, cfg_data
// in       in         in_valid / in_stall  req_type, point_re, point_im, cell_x, cell_y
// out      out        out_valid / out_stall accepted, cell_count, grey_level,
//                                           grey_valid, peak_count
// front: capture, product registers, queue push, one item at a time; a full queue holds the push
// back: insert is a registered memory read, then write and peak update
// read is a registered memory read, plus a bit-serial divide when the peak is nonzero
// clear and reset each run a sweep over all GRID_WIDTH*GRID_HEIGHT cells, one cell a cycle,
// with in_stall high; a full output register holds the back part, the queue keeps the front going
module complex_point_2d_histogram #(
    parameter int GRID_WIDTH  = chp2h_pkg::GridWidthDef,
    parameter int GRID_HEIGHT = chp2h_pkg::GridHeightDef,
    parameter int COUNT_BITS  = chp2h_pkg::CountBitsDef
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [chp2h_pkg::CfgIdxBits-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       req_type,
    input  logic signed [31:0]               point_re,
    input  logic signed [31:0]               point_im,
    input  logic [7:0]                       cell_x,
    input  logic [7:0]                       cell_y,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             accepted,
    output logic [31:0]                      cell_count,
    output logic [7:0]                       grey_level,
    output logic                             grey_valid,
    output logic [31:0]                      peak_count
);
    import chp2h_pkg::*;

    localparam int AW = $clog2(GRID_WIDTH * GRID_HEIGHT);
    localparam int QW = AW + 3;

    logic          q_push;
    logic [QW-1:0] q_push_data;
    logic          q_pop;
    logic [QW-1:0] q_head;
    logic          q_full;
    logic          q_empty;
    logic          sweep_busy;
    res_t          res;

    chp2h_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .AW          (AW),
        .QW          (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .point_re   (point_re),
        .point_im   (point_im),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .sweep_busy (sweep_busy),
        .q_push     (q_push),
        .q_data     (q_push_data),
        .q_full     (q_full)
    );

    chp2h_queue #(
        .DW (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    chp2h_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .COUNT_BITS  (COUNT_BITS),
        .AW          (AW),
        .QW          (QW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .sweep_busy (sweep_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_res    (res)
    );

    assign accepted   = res.accepted;
    assign cell_count = res.cell_count;
    assign grey_level = res.grey_level;
    assign grey_valid = res.grey_valid;
    assign peak_count = res.peak_count;

endmodule

[dv/complex_point_2d_histogram_test.sv]
module complex_point_2d_histogram_test;
    import chp2h_pkg::*;

    typedef struct {
        req_t               kind;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [7:0]         cx;
        logic [7:0]         cy;
    } hist_req_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CfgIdxBits-1:0] cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = REQ_NONE;
    logic signed [31:0] point_re = '0;
    logic signed [31:0] point_im = '0;
    logic [7:0]         cell_x = '0;
    logic [7:0]         cell_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               accepted;
    logic [31:0]        cell_count;
    logic [7:0]         grey_level;
    logic               grey_valid;
    logic [31:0]        peak_count;

    // local copy of the block configuration and histogram
    logic signed [31:0] lo_re = MinRealRst;
    logic signed [31:0] lo_im = MinImagRst;
    logic signed [31:0] hi_re = MaxRealRst;
    logic signed [31:0] hi_im = MaxImagRst;
    logic [31:0]        scale_re = InvBinRealRst;
    logic [31:0]        scale_im = InvBinImagRst;
    int unsigned        bin_tally[int];
    logic [31:0]        peak_tally = '0;

    hist_req_t          pending_reqs[$];
    hist_req_t          cur_req;
    res_t               expected_res[$];
    int                 errors = 0;
    int                 cyc = 0;
    int                 res_seen = 0;
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;

    complex_point_2d_histogram u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .point_re   (point_re),
        .point_im   (point_im),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .accepted   (accepted),
        .cell_count (cell_count),
        .grey_level (grey_level),
        .grey_valid (grey_valid),
        .peak_count (peak_count)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

    // bin index along one axis, clamped to the last bin
    function automatic logic [7:0] axis_bin(logic signed [31:0] coord,
                                            logic signed [31:0] lo, logic [31:0] scale);
        logic [31:0] diff;
        logic [63:0] prod;
        diff = coord - lo;
        prod = {32'd0, diff} * {32'd0, scale};
        if (prod[63:32] > 32'd255)
            return 8'd255;
        return prod[39:32];
    endfunction

    function automatic bit in_rect(logic signed [31:0] re, logic signed [31:0] im);
        return !(re < lo_re || im < lo_im || re > hi_re || im > hi_im);
    endfunction

    // expected result of one accepted request, histogram updated
    function automatic res_t bin_and_grade(hist_req_t r);
        res_t        e;
        int          key;
        logic [63:0] g;
        e = '0;
        case (r.kind)
            REQ_INSERT:
            begin
                if (in_rect(r.re, r.im))
                begin
                    key = {axis_bin(r.im, lo_im, scale_im), axis_bin(r.re, lo_re, scale_re)};
                    if (!bin_tally.exists(key))
                        bin_tally[key] = 0;
                    if (bin_tally[key] != 32'hFFFF_FFFF)
                        bin_tally[key]++;
                    if (bin_tally[key] > peak_tally)
                        peak_tally = bin_tally[key];
                    e.accepted = 1'b1;
                end
            end
            REQ_READ:
            begin
                key = {r.cy, r.cx};
                if (bin_tally.exists(key))
                    e.cell_count = bin_tally[key];
                if (peak_tally != 0)
                begin
                    e.grey_valid = 1'b1;
                    g = (64'(e.cell_count) * 64'd255) / 64'(peak_tally);
                    e.grey_level = (g > 64'd255) ? 8'd255 : g[7:0];
                end
            end
            REQ_CLEAR:
            begin
                bin_tally.delete();
                peak_tally = '0;
            end
            default: ;
        endcase
        e.peak_count = peak_tally;
        return e;
    endfunction

    function automatic bit idle_roll();
        return ((cyc % 5000) >= 1200) && ($urandom_range(99) < 27);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        bit        nv;
        hist_req_t nx;
        cyc <= cyc + 1;
        nv = 1'b0;
        nx = cur_req;
        if (!rst_n)
            nv = 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_res.push_back(bin_and_grade(cur_req));
                void'(pending_reqs.pop_front());
            end
            if (in_valid && in_stall)
                nv = 1'b1;
            else if (pending_reqs.size() > 0 && !idle_roll())
            begin
                nv = 1'b1;
                nx = pending_reqs[0];
            end
        end
        in_valid <= nv;
        cur_req  <= nx;
        req_type <= nx.kind;
        point_re <= nx.re;
        point_im <= nx.im;
        cell_x   <= nx.cx;
        cell_y   <= nx.cy;
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            res_seen <= res_seen + 1;
            if (expected_res.size() == 0)
                report("unexpected item", 0, 0);
            else
            begin
                e = expected_res.pop_front();
                if (accepted !== e.accepted)
                    report("accepted", accepted, e.accepted);
                if (cell_count !== e.cell_count)
                    report("cell_count", cell_count, e.cell_count);
                if (grey_level !== e.grey_level)
                    report("grey_level", grey_level, e.grey_level);
                if (grey_valid !== e.grey_valid)
                    report("grey_valid", grey_valid, e.grey_valid);
                if (peak_count !== e.peak_count)
                    report("peak_count", peak_count, e.peak_count);
            end
        end
    end

    // receiver stall, with one long hold-off
    always @(posedge clk)
    begin
        if (!hold_done && res_seen >= 200)
        begin
            hold_done <= 1'b1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= idle_roll();
    end

    task automatic add_req(req_t k, logic [31:0] re, logic [31:0] im,
                           logic [7:0] cx, logic [7:0] cy);
        hist_req_t r;
        r.kind = k;
        r.re = re;
        r.im = im;
        r.cx = cx;
        r.cy = cy;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_res.size() > 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MIN_REAL:     lo_re = val;
            CFG_MIN_IMAG:     lo_im = val;
            CFG_MAX_REAL:     hi_re = val;
            CFG_MAX_IMAG:     hi_im = val;
            CFG_INV_BIN_REAL: scale_re = val;
            CFG_INV_BIN_IMAG: scale_im = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] l_re, logic [31:0] l_im, logic [31:0] h_re,
                              logic [31:0] h_im, logic [31:0] s_re, logic [31:0] s_im);
        wait_drained();
        write_reg(CFG_MIN_REAL, l_re);
        write_reg(CFG_MIN_IMAG, l_im);
        write_reg(CFG_MAX_REAL, h_re);
        write_reg(CFG_MAX_IMAG, h_im);
        write_reg(CFG_INV_BIN_REAL, s_re);
        write_reg(CFG_INV_BIN_IMAG, s_im);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] pick(longint lo, longint hi);
        longint unsigned r;
        if (hi < lo)
            return lo[31:0];
        r = {$urandom, $urandom};
        return 32'(lo + longint'(r % longint'(hi - lo + 1)));
    endfunction

    // mostly inserts and reads around a few busy cells, with some noise
    task automatic random_phase(int n, bit with_clear);
        logic [31:0] hot_re[8];
        logic [31:0] hot_im[8];
        int          h;
        int          roll;
        for (int i = 0; i < 8; i++)
        begin
            hot_re[i] = pick(lo_re, hi_re);
            hot_im[i] = pick(lo_im, hi_im);
        end
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            h = $urandom_range(7);
            if (with_clear && i == n / 2)
                add_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else if (roll < 40)
                add_req(REQ_INSERT, hot_re[h], hot_im[h], $urandom, $urandom);
            else if (roll < 52)
                add_req(REQ_INSERT, pick(lo_re, hi_re), pick(lo_im, hi_im),
                        $urandom, $urandom);
            else if (roll < 60)
                add_req(REQ_INSERT, $urandom, $urandom, $urandom, $urandom);
            else if (roll < 85)
                add_req(REQ_READ, $urandom, $urandom,
                        axis_bin(hot_re[h], lo_re, scale_re),
                        axis_bin(hot_im[h], lo_im, scale_im));
            else if (roll < 97)
                add_req(REQ_READ, $urandom, $urandom, $urandom, $urandom);
            else
                add_req(REQ_NONE, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    // stimulus
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: bounds, clamping, empty peak, idle code, clear
        add_req(REQ_READ, 0, 0, 8'd0, 8'd0);
        add_req(REQ_INSERT, 32'hFFFE_0000, 32'hFFFE_0000, 8'hFF, 8'hFF);
        add_req(REQ_INSERT, 32'hFFFE_0000, 32'hFFFE_0000, 8'h00, 8'h00);
        add_req(REQ_INSERT, 32'h0002_0000, 32'h0002_0000, 8'h00, 8'h00);
        add_req(REQ_INSERT, 32'hFFFD_FFFF, 32'h0000_0000, 8'h00, 8'h00);
        add_req(REQ_INSERT, 32'h0000_0000, 32'hFFFD_FFFF, 8'h00, 8'h00);
        add_req(REQ_INSERT, 32'h0002_0001, 32'h0000_0000, 8'h00, 8'h00);
        add_req(REQ_INSERT, 32'h0000_0000, 32'h0002_0001, 8'h00, 8'h00);
        add_req(REQ_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 8'h00, 8'h00);
        add_req(REQ_READ, 0, 0, 8'd0, 8'd0);
        add_req(REQ_READ, 0, 0, 8'd255, 8'd255);
        add_req(REQ_READ, 0, 0, 8'd128, 8'd7);
        add_req(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
        add_req(REQ_CLEAR, 0, 0, 8'd0, 8'd0);
        add_req(REQ_READ, 0, 0, 8'd0, 8'd0);
        add_req(REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 8'h00, 8'h00);
        add_req(REQ_READ, 0, 0, 8'd128, 8'd128);
        add_req(REQ_READ, 0, 0, 8'd0, 8'd0);

        random_phase(150, 1'b0);

        // narrow window, steepest scale on one axis, weakest on the other
        set_config(32'hFFFF_0000, 32'hFFFF_8000, 32'h0001_0000, 32'h0001_8000,
                   32'hFFFF_FFFF, 32'h0000_0001);
        random_phase(150, 1'b1);

        // widest window
        set_config(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h0001_0000, 32'h0000_0100);
        add_req(REQ_INSERT, 32'h8000_0000, 32'h8000_0000, 8'h00, 8'h00);
        add_req(REQ_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 8'h00);
        random_phase(120, 1'b0);

        // empty rectangle on the real axis
        set_config(32'h0001_0000, 32'hFFFE_0000, 32'h0000_0000, 32'h0002_0000,
                   32'h0040_0000, 32'h0040_0000);
        random_phase(50, 1'b0);

        // zero scale piles everything into the first cell
        set_config(32'hFFFE_0000, 32'hFFFE_0000, 32'h0002_0000, 32'h0002_0000,
                   32'h0000_0000, 32'h0000_0000);
        random_phase(150, 1'b1);

        while (expected_res.size() > 0 || pending_reqs.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/chp2h_pkg.sv
sv/chp2h_queue.sv
sv/chp2h_front.sv
sv/chp2h_div.sv
sv/chp2h_back.sv
sv/complex_point_2d_histogram.sv
dv/complex_point_2d_histogram_test.sv
